FILE: rtl/core/four_level_page_walker_top_assert.svh
// Assertion macros for the page walker.
// Needs nothing else; the top level includes this file by its bare name.
`ifndef FOUR_LEVEL_PAGE_WALKER_TOP_ASSERT_SVH
`define FOUR_LEVEL_PAGE_WALKER_TOP_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define FLPW_ASSERT_NOW(lbl, ck, rn, ante, cons, msg) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked outside reset.
`define FLPW_ASSERT_NEXT(lbl, ck, rn, ante, cons, msg) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/core/flpw_pkg.sv
// Shared types and constants for the four-level page walker.
// Used by flpw_ram, four_level_page_walker_top, walk_checker and tb_top; depends on nothing.
package flpw_pkg;

    // Item kinds carried on s_tuser
    localparam logic [1:0] MODE_WRITE     = 2'd0;
    localparam logic [1:0] MODE_TRANSLATE = 2'd1;
    localparam logic [1:0] MODE_UNMAP     = 2'd2;

    // Entry flag bits
    localparam int PTE_PRESENT_BIT = 0;
    localparam int PTE_HUGE_BIT    = 7;

    // Index field positions in the virtual address
    localparam int SHIFT_L4 = 39;
    localparam int SHIFT_L3 = 30;
    localparam int SHIFT_L2 = 21;
    localparam int SHIFT_L1 = 12;
    localparam int IDX_W    = 9;

    // Field widths
    localparam int VA_W    = 48;
    localparam int PA_W    = 52;
    localparam int WIDX_W  = 12;
    localparam int ENTRY_W = 64;
    localparam int MODE_W  = 2;
    localparam int FRAME_W = PA_W - SHIFT_L1;       // entry bits 51..12
    localparam int WSUM_W  = FRAME_W + IDX_W;       // word number before wrap

    localparam int S_TDATA_W = VA_W + PA_W + WIDX_W + ENTRY_W;  // 176, whole bytes
    localparam int M_TDATA_W = 56;                              // phys_addr padded

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_L4,
        ST_L3,
        ST_L2,
        ST_L1,
        ST_FINISH
    } state_t;

    function automatic logic [IDX_W-1:0] level_index(input logic [VA_W-1:0] va,
                                                     input int shift);
        level_index = IDX_W'(va >> shift);
    endfunction

endpackage

FILE: rtl/core/flpw_ram.sv
// Table memory of the page walker: one write port, one read port, registered read.
// Depends on flpw_pkg for the entry width.
module flpw_ram #(
    parameter int TABLE_WORDS = 4096,
    parameter int ADDR_W      = 12
) (
    input  logic                             clk,
    input  logic                             wr_en,
    input  logic [ADDR_W-1:0]                wr_addr,
    input  logic [flpw_pkg::ENTRY_W-1:0]     wr_data,
    input  logic                             rd_en,
    input  logic [ADDR_W-1:0]                rd_addr,
    output logic [flpw_pkg::ENTRY_W-1:0]     rd_data
);

    logic [flpw_pkg::ENTRY_W-1:0] mem [TABLE_WORDS];
    logic [flpw_pkg::ENTRY_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: rtl/core/four_level_page_walker_top.sv
// Four-level page walker: table memory, walk sequencer and result register.
// Depends on flpw_pkg, flpw_ram and four_level_page_walker_top_assert.svh.
//
//  channel | direction | tdata                                   | tuser
//  --------+-----------+-----------------------------------------+-----------
//  s_*     | in        | virt_addr, table_root, word_index,      | mode
//          |           | word_value (176 bits)                   |
//  m_*     | out       | phys_addr, zero pad to 56 bits          | found
//
// After rst_n releases, the table memory is swept to zero, one word per cycle,
// through all TABLE_WORDS words; s_tready stays low until the sweep ends.
// One item at a time: a write or an unused mode goes from idle straight to the
// finish state; a translate or unmap first makes up to four dependent reads of
// the single read port, one per walk level, before it finishes.
// A finished result waits in a pending register while the output register is
// full; s_tready returns as soon as the sequencer is back in idle.
module four_level_page_walker_top #(
    parameter int TABLE_WORDS = 4096     // power of two, 512 to 1048576
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // s_tdata: virt_addr[47:0], table_root[99:48], word_index[111:100],
    //          word_value[175:112]
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [flpw_pkg::S_TDATA_W-1:0]      s_tdata,
    // s_tuser: mode[1:0]
    input  logic [flpw_pkg::MODE_W-1:0]         s_tuser,
    // m_tdata: phys_addr[51:0], zero[55:52]
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [flpw_pkg::M_TDATA_W-1:0]      m_tdata,
    // m_tuser: found[0]
    output logic                                m_tuser
);

    localparam int ADDR_W = $clog2(TABLE_WORDS);
    localparam logic [ADDR_W-1:0] LAST_WORD = ADDR_W'(TABLE_WORDS - 1);

    // unpack the input item
    logic [flpw_pkg::VA_W-1:0]     in_va;
    logic [flpw_pkg::PA_W-1:0]     in_root;
    logic [flpw_pkg::WIDX_W-1:0]   in_widx;
    logic [flpw_pkg::ENTRY_W-1:0]  in_wval;

    assign in_va   = s_tdata[47:0];
    assign in_root = s_tdata[99:48];
    assign in_widx = s_tdata[111:100];
    assign in_wval = s_tdata[175:112];

    flpw_pkg::state_t state_reg, state_next;

    logic [ADDR_W-1:0]             clr_cnt_reg;
    logic [flpw_pkg::MODE_W-1:0]   mode_reg;
    logic [flpw_pkg::VA_W-1:0]     va_reg;

    logic [flpw_pkg::PA_W-1:0]     res_phys_reg, res_phys_next;
    logic                          res_found_reg, res_found_next;
    logic                          res_load;

    logic [flpw_pkg::PA_W-1:0]     out_phys_reg;
    logic                          out_found_reg;
    logic                          out_valid_reg;
    logic                          out_load;

    // memory port signals
    logic                          wr_en;
    logic [ADDR_W-1:0]             wr_addr;
    logic [flpw_pkg::ENTRY_W-1:0]  wr_data;
    logic                          rd_en;
    logic [ADDR_W-1:0]             rd_addr;
    logic [flpw_pkg::ENTRY_W-1:0]  rd_data;

    // walk address: frame number and level index, wrapped to the memory size
    logic [flpw_pkg::FRAME_W-1:0]  walk_frame;
    logic [flpw_pkg::IDX_W-1:0]    walk_idx;
    logic [flpw_pkg::WSUM_W-1:0]   walk_word;
    logic [flpw_pkg::WSUM_W-1:0]   widx_word;

    logic                          ent_present;
    logic                          ent_huge;
    logic                          is_unmap;

    assign ent_present = rd_data[flpw_pkg::PTE_PRESENT_BIT];
    assign ent_huge    = rd_data[flpw_pkg::PTE_HUGE_BIT];
    assign is_unmap    = (mode_reg == flpw_pkg::MODE_UNMAP);

    always_comb
    begin
        case (state_reg)
            flpw_pkg::ST_IDLE:
            begin
                walk_frame = in_root[flpw_pkg::PA_W-1:flpw_pkg::SHIFT_L1];
                walk_idx   = flpw_pkg::level_index(in_va, flpw_pkg::SHIFT_L4);
            end
            flpw_pkg::ST_L4:
            begin
                walk_frame = rd_data[flpw_pkg::PA_W-1:flpw_pkg::SHIFT_L1];
                walk_idx   = flpw_pkg::level_index(va_reg, flpw_pkg::SHIFT_L3);
            end
            flpw_pkg::ST_L3:
            begin
                walk_frame = rd_data[flpw_pkg::PA_W-1:flpw_pkg::SHIFT_L1];
                walk_idx   = flpw_pkg::level_index(va_reg, flpw_pkg::SHIFT_L2);
            end
            default:
            begin
                walk_frame = rd_data[flpw_pkg::PA_W-1:flpw_pkg::SHIFT_L1];
                walk_idx   = flpw_pkg::level_index(va_reg, flpw_pkg::SHIFT_L1);
            end
        endcase
    end

    assign walk_word = {walk_frame, walk_idx};
    assign widx_word = flpw_pkg::WSUM_W'(in_widx);
    assign rd_addr   = walk_word[ADDR_W-1:0];

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            flpw_pkg::ST_CLEAR:
            begin
                if (clr_cnt_reg == LAST_WORD)
                begin
                    state_next = flpw_pkg::ST_IDLE;
                end
            end
            flpw_pkg::ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    if (s_tuser == flpw_pkg::MODE_TRANSLATE || s_tuser == flpw_pkg::MODE_UNMAP)
                    begin
                        state_next = flpw_pkg::ST_L4;
                    end
                    else
                    begin
                        state_next = flpw_pkg::ST_FINISH;
                    end
                end
            end
            flpw_pkg::ST_L4:
            begin
                state_next = ent_present ? flpw_pkg::ST_L3 : flpw_pkg::ST_FINISH;
            end
            flpw_pkg::ST_L3:
            begin
                state_next = (ent_present && !ent_huge) ? flpw_pkg::ST_L2
                                                        : flpw_pkg::ST_FINISH;
            end
            flpw_pkg::ST_L2:
            begin
                state_next = (ent_present && !ent_huge && !is_unmap) ? flpw_pkg::ST_L1
                                                                     : flpw_pkg::ST_FINISH;
            end
            flpw_pkg::ST_L1:
            begin
                state_next = flpw_pkg::ST_FINISH;
            end
            flpw_pkg::ST_FINISH:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    state_next = flpw_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = flpw_pkg::ST_IDLE;
            end
        endcase
    end

    // state outputs: memory ports and pending result
    always_comb
    begin
        s_tready       = 1'b0;
        rd_en          = 1'b0;
        wr_en          = 1'b0;
        wr_addr        = walk_word[ADDR_W-1:0];
        wr_data        = '0;
        res_load       = 1'b0;
        res_phys_next  = '0;
        res_found_next = 1'b0;
        case (state_reg)
            flpw_pkg::ST_CLEAR:
            begin
                wr_en   = 1'b1;
                wr_addr = clr_cnt_reg;
            end
            flpw_pkg::ST_IDLE:
            begin
                s_tready = 1'b1;
                res_load = s_tvalid;
                if (s_tvalid)
                begin
                    // write stores its word; the walk modes fetch the top entry
                    if (s_tuser == flpw_pkg::MODE_WRITE)
                    begin
                        wr_en   = 1'b1;
                        wr_addr = widx_word[ADDR_W-1:0];
                        wr_data = in_wval;
                    end
                    rd_en = (s_tuser == flpw_pkg::MODE_TRANSLATE) ||
                            (s_tuser == flpw_pkg::MODE_UNMAP);
                end
            end
            flpw_pkg::ST_L4:
            begin
                rd_en    = ent_present;
                res_load = !ent_present;
            end
            flpw_pkg::ST_L3:
            begin
                rd_en    = ent_present && !ent_huge;
                res_load = !(ent_present && !ent_huge);
                if (ent_present && ent_huge && !is_unmap)
                begin
                    res_phys_next  = {rd_data[flpw_pkg::PA_W-1:flpw_pkg::SHIFT_L3],
                                      va_reg[flpw_pkg::SHIFT_L3-1:0]};
                    res_found_next = 1'b1;
                end
            end
            flpw_pkg::ST_L2:
            begin
                rd_en    = ent_present && !ent_huge && !is_unmap;
                res_load = !(ent_present && !ent_huge && !is_unmap);
                if (ent_present && ent_huge && !is_unmap)
                begin
                    res_phys_next  = {rd_data[flpw_pkg::PA_W-1:flpw_pkg::SHIFT_L2],
                                      va_reg[flpw_pkg::SHIFT_L2-1:0]};
                    res_found_next = 1'b1;
                end
                if (ent_present && !ent_huge && is_unmap)
                begin
                    // clear the leaf whether it was present or not
                    wr_en          = 1'b1;
                    res_found_next = 1'b1;
                end
            end
            flpw_pkg::ST_L1:
            begin
                res_load = 1'b1;
                if (ent_present)
                begin
                    res_phys_next  = {rd_data[flpw_pkg::PA_W-1:flpw_pkg::SHIFT_L1],
                                      va_reg[flpw_pkg::SHIFT_L1-1:0]};
                    res_found_next = 1'b1;
                end
            end
            default:
            begin
                res_load = 1'b0;
            end
        endcase
    end

    assign out_load = (state_reg == flpw_pkg::ST_FINISH) && (!out_valid_reg || m_tready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= flpw_pkg::ST_CLEAR;
            clr_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == flpw_pkg::ST_CLEAR)
            begin
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers: hold the item fields, the pending result and the output
    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            mode_reg <= s_tuser;
            va_reg   <= in_va;
        end
        if (res_load)
        begin
            res_phys_reg  <= res_phys_next;
            res_found_reg <= res_found_next;
        end
        if (out_load)
        begin
            out_phys_reg  <= res_phys_reg;
            out_found_reg <= res_found_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = flpw_pkg::M_TDATA_W'(out_phys_reg);
    assign m_tuser  = out_found_reg;

    flpw_ram #(
        .TABLE_WORDS (TABLE_WORDS),
        .ADDR_W      (ADDR_W)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

`include "four_level_page_walker_top_assert.svh"

    // only the sweep and the unmap path write zeros; only idle writes item data
    `FLPW_ASSERT_NOW(a_zero_write, clk, rst_n, wr_en && state_reg != flpw_pkg::ST_IDLE, wr_data == '0, "table write outside idle carries nonzero data")

    // no item is taken and no result is offered while the sweep runs
    `FLPW_ASSERT_NOW(a_no_accept_in_clear, clk, rst_n, state_reg == flpw_pkg::ST_CLEAR, !s_tready && !m_tvalid, "handshake active during table sweep")

    // a finishing result that finds room appears on the output next cycle
    `FLPW_ASSERT_NEXT(a_finish_lands, clk, rst_n, out_load, m_tvalid && state_reg == flpw_pkg::ST_IDLE, "finished result did not reach the output register")

    // an unmap write happens only at the second level of an unmap walk
    `FLPW_ASSERT_NOW(a_unmap_write, clk, rst_n, wr_en && state_reg == flpw_pkg::ST_L2, is_unmap && res_found_next, "leaf clear outside an unmap walk")

endmodule

FILE: test/walk_checker.sv
// Walk checker: watches both streams of the page walker, predicts each result and compares.
// Depends on flpw_pkg for mode codes and entry flag positions.
module walk_checker #(
    parameter int TABLE_WORDS = 4096
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [175:0] s_tdata,
    input  logic [1:0]  s_tuser,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [55:0] m_tdata,
    input  logic        m_tuser,
    output int          fail_count,
    output int          outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [51:0] phys;
        logic        found;
    } walk_result_t;

    logic [63:0]  page_mem [TABLE_WORDS];
    walk_result_t predicted_walks [$];
    walk_result_t want;

    // Word that holds entry (va >> shift)[8:0] of the table at base, wrapped to TABLE_WORDS.
    function automatic int unsigned entry_slot(input logic [51:0] base, input logic [47:0] va,
                                               input int shift);
        logic [8:0]  idx;
        logic [63:0] sum;
        idx = 9'(va >> shift);
        sum = (64'(base[51:12]) << 9) + 64'(idx);
        return int'(sum % TABLE_WORDS);
    endfunction

    // Apply one item to the table copy and return the result it must produce.
    function automatic walk_result_t apply_item(input logic [1:0] mode, input logic [47:0] va,
                                                input logic [51:0] root,
                                                input logic [11:0] widx,
                                                input logic [63:0] wval);
        walk_result_t r;
        logic [63:0]  e4, e3, e2;
        int unsigned  leaf;
        r = '0;
        if (mode == flpw_pkg::MODE_WRITE)
        begin
            page_mem[widx % TABLE_WORDS] = wval;
            return r;
        end
        if (mode != flpw_pkg::MODE_TRANSLATE && mode != flpw_pkg::MODE_UNMAP)
            return r;
        e4 = page_mem[entry_slot(root, va, flpw_pkg::SHIFT_L4)];
        if (!e4[flpw_pkg::PTE_PRESENT_BIT])
            return r;
        e3 = page_mem[entry_slot(e4[51:0], va, flpw_pkg::SHIFT_L3)];
        if (!e3[flpw_pkg::PTE_PRESENT_BIT])
            return r;
        if (e3[flpw_pkg::PTE_HUGE_BIT])
        begin
            // 1 GB page: unmap stops here without clearing
            if (mode == flpw_pkg::MODE_TRANSLATE)
            begin
                r.phys  = {e3[51:30], va[29:0]};
                r.found = 1'b1;
            end
            return r;
        end
        e2 = page_mem[entry_slot(e3[51:0], va, flpw_pkg::SHIFT_L2)];
        if (!e2[flpw_pkg::PTE_PRESENT_BIT])
            return r;
        if (e2[flpw_pkg::PTE_HUGE_BIT])
        begin
            if (mode == flpw_pkg::MODE_TRANSLATE)
            begin
                r.phys  = {e2[51:21], va[20:0]};
                r.found = 1'b1;
            end
            return r;
        end
        leaf = entry_slot(e2[51:0], va, flpw_pkg::SHIFT_L1);
        if (mode == flpw_pkg::MODE_UNMAP)
        begin
            page_mem[leaf] = '0;
            r.found        = 1'b1;
        end
        else if (page_mem[leaf][flpw_pkg::PTE_PRESENT_BIT])
        begin
            r.phys  = {page_mem[leaf][51:12], va[11:0]};
            r.found = 1'b1;
        end
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            foreach (page_mem[i])
                page_mem[i] = '0;
            predicted_walks.delete();
            fail_count  = 0;
            outstanding = 0;
        end
        else
        begin
            if (s_tvalid && s_tready)
                predicted_walks.push_back(apply_item(s_tuser, s_tdata[47:0], s_tdata[99:48],
                                                     s_tdata[111:100], s_tdata[175:112]));
            if (m_tvalid && m_tready)
            begin
                if (predicted_walks.size() == 0)
                begin
                    $display("%0t: unexpected result: phys_addr %h found %b",
                             $time, m_tdata[51:0], m_tuser);
                    fail_count++;
                end
                else
                begin
                    want = predicted_walks.pop_front();
                    if (m_tdata[51:0] !== want.phys || m_tdata[55:52] !== 4'h0
                        || m_tuser !== want.found)
                    begin
                        $display("%0t: mismatch: expected phys_addr %h pad 0 found %b, got %h pad %h found %b",
                                 $time, want.phys, want.found, m_tdata[51:0], m_tdata[55:52],
                                 m_tuser);
                        fail_count++;
                    end
                end
            end
            outstanding = predicted_walks.size();
        end
    end

endmodule

FILE: test/tb_top.sv
// Top of the page walker regression: clock, reset, stimulus on both streams and the verdict.
// Depends on flpw_pkg, four_level_page_walker_top and walk_checker.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int          WORDS       = 4096;
    localparam logic [1:0]  MODE_SPARE  = 2'd3;     // no operation, still answers
    localparam int          TOTAL_ITEMS = 1050;
    localparam int          LONG_HOLD   = 150;      // receiver hold-off, in cycles
    localparam int          SETTLE      = 20;       // cycles after the last result

    logic         clk;
    logic         rst_n;
    logic         s_tvalid;
    logic         s_tready;
    logic [175:0] s_tdata;      // virt_addr, table_root, word_index, word_value
    logic [1:0]   s_tuser;      // mode
    logic         m_tvalid;
    logic         m_tready;
    logic [55:0]  m_tdata;      // phys_addr, zero pad
    logic         m_tuser;      // found

    int           fail_count;
    int           outstanding;
    int           items_sent;
    int           results_taken;
    logic         no_idle;      // sender and receiver add no random gaps while set

    four_level_page_walker_top #(.TABLE_WORDS(WORDS)) uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    walk_checker #(.TABLE_WORDS(WORDS)) u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .fail_count  (fail_count),
        .outstanding (outstanding)
    );

    initial clk = 1'b0;
    always #2 clk = ~clk;

    function automatic logic [63:0] rand_word();
        return {$urandom, $urandom};
    endfunction

    // Random table entry pointing at table tbl (entry bits 14..12 pick one of eight
    // 512-word tables in the 4096-word store); all bits but those and the two flags are noise.
    function automatic logic [63:0] make_entry(input logic [2:0] tbl, input logic present,
                                               input logic huge);
        logic [63:0] e;
        e                            = rand_word();
        e[14:12]                     = tbl;
        e[flpw_pkg::PTE_PRESENT_BIT] = present;
        e[flpw_pkg::PTE_HUGE_BIT]    = huge;
        return e;
    endfunction

    // Offer one item after a random gap and hold it until the block takes it.
    // Enter and leave at a falling edge; keep tvalid high when no gap follows.
    task automatic send_item(input logic [1:0] mode, input logic [47:0] va,
                             input logic [51:0] root, input logic [11:0] widx,
                             input logic [63:0] wval);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 4);
        if (gap > 0)
        begin
            s_tvalid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tdata  = {wval, widx, root, va};
        s_tuser  = mode;
        s_tvalid = 1'b1;
        do
            @(posedge clk);
        while (!s_tready);
        @(negedge clk);
        items_sent++;
    endtask

    // Store one table word; the address fields carry noise.
    task automatic write_word(input logic [11:0] widx, input logic [63:0] wval);
        send_item(flpw_pkg::MODE_WRITE, 48'(rand_word()), 52'(rand_word()), widx, wval);
    endtask

    // Translate or unmap; the write fields carry noise.
    task automatic walk_op(input logic [1:0] mode, input logic [47:0] va,
                           input logic [51:0] root);
        send_item(mode, va, root, 12'($urandom), rand_word());
    endtask

    // Write a walk for va from root down to a leaf at leaf_level (1: 4 KB, 2: 2 MB,
    // 3: 1 GB). hole_level, if not 0, is the level whose entry is left not present.
    // The four tables sit at distinct slots, an odd stride apart, so no entry of the
    // walk overwrites another.
    task automatic build_walk(input logic [51:0] root, input logic [47:0] va,
                              input int leaf_level, input int hole_level);
        logic [2:0] stride, t4, t3, t2, t1;
        stride = 3'(2 * $urandom_range(0, 3) + 1);
        t4     = root[14:12];
        t3     = t4 + stride;
        t2     = t3 + stride;
        t1     = t2 + stride;
        // top-level huge bit means nothing; let it toggle
        write_word({t4, va[47:39]}, make_entry(t3, hole_level != 4, 1'($urandom)));
        if (leaf_level == 3)
        begin
            write_word({t3, va[38:30]}, make_entry(3'($urandom), hole_level != 3, 1'b1));
            return;
        end
        write_word({t3, va[38:30]}, make_entry(t2, hole_level != 3, 1'b0));
        if (leaf_level == 2)
        begin
            write_word({t2, va[29:21]}, make_entry(3'($urandom), hole_level != 2, 1'b1));
            return;
        end
        write_word({t2, va[29:21]}, make_entry(t1, hole_level != 2, 1'b0));
        write_word({t1, va[20:12]}, make_entry(3'($urandom), hole_level != 1, 1'($urandom)));
    endtask

    // Drop tvalid and hold until every predicted result has come back.
    task automatic drain_results();
        s_tvalid = 1'b0;
        while (outstanding != 0)
            @(negedge clk);
    endtask

    // Receiver: random stall per item, two long hold-offs that back the block up
    // into its input, and no random stalls while no_idle is set.
    initial
    begin
        int stall;
        m_tready      = 1'b0;
        results_taken = 0;
        wait (rst_n);
        @(negedge clk);
        forever
        begin
            stall = no_idle ? 0 : $urandom_range(0, 4);
            if (results_taken == 300 || results_taken == 700)
                stall = LONG_HOLD;
            if (stall > 0)
            begin
                m_tready = 1'b0;
                repeat (stall) @(negedge clk);
            end
            m_tready = 1'b1;
            do
                @(posedge clk);
            while (!m_tvalid);
            results_taken++;
            @(negedge clk);
        end
    end

    // Sender and verdict.
    initial
    begin
        logic [51:0] root, root_op;
        logic [47:0] va, va_op, off_mask;
        int          leaf, hole, pick, scenario;
        rst_n      = 1'b0;
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        s_tuser    = flpw_pkg::MODE_WRITE;
        no_idle    = 1'b0;
        items_sent = 0;
        scenario   = 0;
        repeat (11) @(negedge clk);
        rst_n = 1'b1;

        // Directed: empty store, unused mode, all-ones fields
        walk_op(flpw_pkg::MODE_TRANSLATE, '0, '0);
        walk_op(flpw_pkg::MODE_UNMAP, '1, '1);
        send_item(MODE_SPARE, '1, '1, '1, '1);
        // An all-ones word at the last slot points back at itself: the walk from an
        // all-ones root and address ends on it as a 1 GB page, and unmap refuses it.
        write_word('1, '1);
        walk_op(flpw_pkg::MODE_TRANSLATE, '1, '1);
        walk_op(flpw_pkg::MODE_UNMAP, '1, '1);
        write_word('0, '0);
        // 4 KB page: hit, unmap, miss, then unmap of a cleared leaf still reports found
        build_walk('0, '0, 1, 0);
        walk_op(flpw_pkg::MODE_TRANSLATE, 48'hABC, '0);
        walk_op(flpw_pkg::MODE_UNMAP, '0, '0);
        walk_op(flpw_pkg::MODE_TRANSLATE, 48'hFFF, '0);
        walk_op(flpw_pkg::MODE_UNMAP, '0, '0);
        // 2 MB page: hit, unmap leaves it alone
        build_walk(52'h5000, 48'h1234_5678_9ABC, 2, 0);
        walk_op(flpw_pkg::MODE_TRANSLATE, 48'h1234_567F_FFFF, 52'h5000);
        walk_op(flpw_pkg::MODE_UNMAP, 48'h1234_5678_9ABC, 52'h5000);
        // not present at the third level
        build_walk(52'h3000, 48'h8000_4020_1000, 1, 3);
        walk_op(flpw_pkg::MODE_TRANSLATE, 48'h8000_4020_1000, 52'h3000);
        drain_results();

        // Random: mostly well-formed walks with noisy content, some broken walks and
        // some plain noise items
        while (items_sent < TOTAL_ITEMS)
        begin
            scenario++;
            no_idle = ($urandom_range(0, 7) == 0);
            if (scenario % 40 == 0)
                drain_results();
            pick = $urandom_range(0, 19);
            if (pick < 3)
            begin
                repeat ($urandom_range(1, 4))
                    send_item(2'($urandom), 48'(rand_word()), 52'(rand_word()),
                              12'($urandom), rand_word());
                continue;
            end
            root = 52'(rand_word());
            va   = 48'(rand_word());
            leaf = ($urandom_range(0, 1) == 0) ? 1 : $urandom_range(2, 3);
            hole = (pick < 6) ? $urandom_range(leaf, 4) : 0;
            build_walk(root, va, leaf, hole);
            // vary only the page offset and the root bits outside 14..12 so the walk stays on the same entries
            off_mask = (leaf == 3) ? 48'h3FFF_FFFF : (leaf == 2) ? 48'h1F_FFFF : 48'hFFF;
            repeat ($urandom_range(1, 3))
            begin
                va_op   = (va & ~off_mask) | (48'(rand_word()) & off_mask);
                root_op = (52'(rand_word()) & ~52'h7000) | (root & 52'h7000);
                pick    = $urandom_range(0, 9);
                walk_op((pick < 6) ? flpw_pkg::MODE_TRANSLATE
                                   : (pick < 9) ? flpw_pkg::MODE_UNMAP : MODE_SPARE,
                        va_op, root_op);
            end
        end
        no_idle = 1'b0;

        drain_results();
        repeat (SETTLE) @(negedge clk);
        if (fail_count == 0)
            $display("four_level_page_walker_top regression: pass");
        else
            $display("four_level_page_walker_top regression: fail");
        $finish;
    end

    // Run limit: far beyond the slowest legal run, including the clearing sweep.
    initial
    begin
        #1_000_000;
        $display("four_level_page_walker_top regression: fail");
        $finish;
    end

endmodule

FILE: four_level_page_walker_top.f
+incdir+rtl/core
rtl/core/flpw_pkg.sv
rtl/core/flpw_ram.sv
rtl/core/four_level_page_walker_top.sv
test/walk_checker.sv
test/tb_top.sv
